/* src/mexp_pkg.sv */
package mexp_pkg;

    localparam int DATA_W        = 32;
    localparam int WIDTH_DEFAULT = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RED,
        S_RED_DONE,
        S_MSTART,
        S_MUL,
        S_MDONE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic reduce;
        logic commit_red;
        logic commit_bit;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic m_zero;
        logic e_zero;
        logic cnt_last;
    } t_dp_sts;

endpackage

/* src/mexp_mulmod.sv */
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_start,
    input  logic             i_step,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_m,
    output logic [WIDTH-1:0] o_acc
);

    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] n_y;
    logic [WIDTH-1:0] dbl;

    // (a + b) mod m for a, b < m
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] a,
        input logic [WIDTH-1:0] b,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH-1:0] gap;
        gap = m - b;
        if (a >= gap) begin
            return a - gap;
        end
        return a + b;
    endfunction

    always_comb begin
        dbl   = add_mod(r_acc, r_acc, i_m);
        n_acc = r_acc;
        n_y   = r_y;
        if (i_start) begin
            n_acc = '0;
            n_y   = i_y;
        end else if (i_step) begin
            n_acc = r_y[WIDTH-1] ? add_mod(dbl, i_x, i_m) : dbl;
            n_y   = {r_y[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_y   <= n_y;
    end

    assign o_acc = r_acc;

endmodule

/* src/mexp_datapath.sv */
module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [DATA_W-1:0] i_base,
    input  logic [DATA_W-1:0] i_exponent,
    input  logic [DATA_W-1:0] i_modulus,
    output t_dp_sts           o_sts,
    output logic [DATA_W-1:0] o_result,
    output logic              o_zero_modulus_error
);

    localparam int IN_W  = (WIDTH < DATA_W) ? WIDTH : DATA_W;
    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0]  b_in;
    logic [WIDTH-1:0]  e_in;
    logic [WIDTH-1:0]  m_in;
    logic [WIDTH-1:0]  r_m;
    logic [WIDTH-1:0]  r_e;
    logic [WIDTH-1:0]  r_value;
    logic [WIDTH-1:0]  r_sq;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_result;
    logic              r_err;
    logic [WIDTH-1:0]  acc_a;
    logic [WIDTH-1:0]  acc_b;
    logic [WIDTH-1:0]  x_b;

    assign b_in = WIDTH'(i_base[IN_W-1:0]);
    assign e_in = WIDTH'(i_exponent[IN_W-1:0]);
    assign m_in = WIDTH'(i_modulus[IN_W-1:0]);

    assign x_b = i_cmd.reduce ? r_value : r_sq;

    mexp_mulmod #(.WIDTH(WIDTH)) u_mul_value (
        .i_clk   (i_clk),
        .i_start (i_cmd.start),
        .i_step  (i_cmd.step),
        .i_x     (r_value),
        .i_y     (r_sq),
        .i_m     (r_m),
        .o_acc   (acc_a)
    );

    mexp_mulmod #(.WIDTH(WIDTH)) u_mul_square (
        .i_clk   (i_clk),
        .i_start (i_cmd.start),
        .i_step  (i_cmd.step),
        .i_x     (x_b),
        .i_y     (r_sq),
        .i_m     (r_m),
        .o_acc   (acc_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m     <= m_in;
            r_e     <= e_in;
            r_sq    <= b_in;
            r_value <= (e_in != '0 && m_in == WIDTH'(1)) ? '0 : WIDTH'(1);
        end
        if (i_cmd.commit_red) begin
            r_sq <= acc_b;
        end
        if (i_cmd.commit_bit) begin
            if (r_e[0]) begin
                r_value <= acc_a;
            end
            r_sq <= acc_b;
            r_e  <= r_e >> 1;
        end
        if (i_cmd.start) begin
            r_cnt <= CNT_W'(WIDTH - 1);
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.finish) begin
            r_err    <= (r_m == '0);
            r_result <= (r_m == '0) ? '0 : DATA_W'(r_value);
        end
    end

    assign o_sts.m_zero       = (r_m == '0);
    assign o_sts.e_zero       = (r_e == '0);
    assign o_sts.cnt_last     = (r_cnt == '0);
    assign o_result             = r_result;
    assign o_zero_modulus_error = r_err;

    a_value_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_bit |=> (r_value < r_m))
        else $error("running value not reduced after exponent bit");

    a_square_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit_red || i_cmd.commit_bit) |=> (r_sq < r_m))
        else $error("square not reduced");

endmodule

/* src/mexp_ctrl.sv */
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.m_zero || i_sts.e_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.start  = 1'b1;
                    o_cmd.reduce = 1'b1;
                    n_state      = S_RED;
                end
            end
            S_RED: begin
                o_cmd.step   = 1'b1;
                o_cmd.reduce = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_RED_DONE;
                end
            end
            S_RED_DONE: begin
                o_cmd.commit_red = 1'b1;
                n_state          = S_MSTART;
            end
            S_MSTART: begin
                if (i_sts.e_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_MDONE;
                end
            end
            S_MDONE: begin
                o_cmd.commit_bit = 1'b1;
                n_state          = S_MSTART;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_load_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted beat did not start a job");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside finish");

endmodule

/* src/modular_exponentiation.sv */
// Channel | Direction | Handshake                  | Payload
// input   | in        | i_in_valid / o_in_ready    | i_base, i_exponent, i_modulus
// output  | out       | o_out_valid / i_out_ready  | o_result, o_zero_modulus_error
//
// One beat is loaded and checked, the base is reduced by a pass of the bit-serial modular
// multipliers, and then further passes handle the exponent one bit at a time, up to its top
// set bit. Zero modulus or zero exponent goes straight from the check to the finish state.
// Reset is synchronous, active low, and clears the controller and output valid.
// A finished result waits in the output register while the next input beat is taken.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [DATA_W-1:0] i_base,
    input  logic [DATA_W-1:0] i_exponent,
    input  logic [DATA_W-1:0] i_modulus,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_result,
    output logic              o_zero_modulus_error
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mexp_datapath #(.WIDTH(WIDTH)) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_base               (i_base),
        .i_exponent           (i_exponent),
        .i_modulus            (i_modulus),
        .o_sts                (sts),
        .o_result             (o_result),
        .o_zero_modulus_error (o_zero_modulus_error)
    );

endmodule

/* bench/mexp_checker.sv */
module mexp_checker
    import mexp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [DATA_W-1:0] i_base,
    input  logic [DATA_W-1:0] i_exponent,
    input  logic [DATA_W-1:0] i_modulus,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [DATA_W-1:0] i_result,
    input  logic              i_zero_modulus_error,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              zero_modulus_error;
    } t_mexp_result;

    t_mexp_result expected_powers[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic t_mexp_result modexp_predict(
        input logic [DATA_W-1:0] base,
        input logic [DATA_W-1:0] exponent,
        input logic [DATA_W-1:0] modulus
    );
        t_mexp_result      r;
        logic [63:0]       acc;
        logic [63:0]       square;
        logic [63:0]       m64;
        logic [DATA_W-1:0] bits;
        r.result             = '0;
        r.zero_modulus_error = 1'b1;
        if (modulus == '0) begin
            return r;
        end
        m64    = 64'(modulus);
        acc    = 64'd1;
        square = 64'(base) % m64;
        bits   = exponent;
        while (bits != '0) begin
            if (bits[0]) begin
                acc = ((acc % m64) * square) % m64;
            end
            square = (square * square) % m64;
            bits   = bits >> 1;
        end
        r.result             = acc[DATA_W-1:0];
        r.zero_modulus_error = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_mexp_result want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_powers.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: result beat %h err %b with nothing outstanding",
                                 $realtime, i_result, i_zero_modulus_error);
                    end
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want      = expected_powers.pop_front();
                    o_checked = o_checked + 1;
                    if (want.result !== i_result ||
                        want.zero_modulus_error !== i_zero_modulus_error) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: mismatch result exp %h got %h, err exp %b got %b",
                                     $realtime, want.result, i_result,
                                     want.zero_modulus_error, i_zero_modulus_error);
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_powers.push_back(modexp_predict(i_base, i_exponent, i_modulus));
            end
            o_pending = expected_powers.size();
        end
    end

endmodule

/* bench/tb.sv */
module tb
    import mexp_pkg::*;
;

    localparam int HOLD_CYCLES  = 3000;
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_BEATS = 520;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [DATA_W-1:0] i_base     = '0;
    logic [DATA_W-1:0] i_exponent = '0;
    logic [DATA_W-1:0] i_modulus  = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DATA_W-1:0] o_result;
    logic              o_zero_modulus_error;

    int fail_count;
    int pending;
    int checked;
    int idle_cycles;
    int n_sent;
    int n_zero_mod;
    int n_zero_exp;

    modular_exponentiation u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_base               (i_base),
        .i_exponent           (i_exponent),
        .i_modulus            (i_modulus),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_result             (o_result),
        .o_zero_modulus_error (o_zero_modulus_error)
    );

    mexp_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_ready           (o_in_ready),
        .i_base               (i_base),
        .i_exponent           (i_exponent),
        .i_modulus            (i_modulus),
        .i_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .i_result             (o_result),
        .i_zero_modulus_error (o_zero_modulus_error),
        .o_fail_count         (fail_count),
        .o_pending            (pending),
        .o_checked            (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 4);
        end else if (r < 97) begin
            return $urandom_range(5, 30);
        end
        return $urandom_range(100, 1500);
    endfunction

    function automatic logic [DATA_W-1:0] pick_modulus();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end else if (r < 10) begin
            return DATA_W'(1);
        end else if (r < 20) begin
            return DATA_W'($urandom_range(2, 255));
        end else if (r < 35) begin
            return DATA_W'($urandom) | (DATA_W'(1) << (DATA_W - 1));
        end
        return DATA_W'($urandom);
    endfunction

    function automatic logic [DATA_W-1:0] pick_exponent();
        int                len;
        logic [DATA_W-1:0] e;
        logic [DATA_W-1:0] one;
        one = DATA_W'(1);
        len = $urandom_range(0, DATA_W);
        if (len == 0) begin
            return '0;
        end
        e = DATA_W'($urandom);
        if (len < DATA_W) begin
            e = e & ((one << len) - one);
        end
        e[len-1] = 1'b1;
        return e;
    endfunction

    task automatic send_operands(
        input logic [DATA_W-1:0] base,
        input logic [DATA_W-1:0] exponent,
        input logic [DATA_W-1:0] modulus,
        input int                gap
    );
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        i_modulus  <= modulus;
        n_sent++;
        if (modulus == '0) begin
            n_zero_mod++;
        end else if (exponent == '0) begin
            n_zero_exp++;
        end
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // drain side: random stalls, plus a long hold-off at set beat counts
    initial begin
        int rx_beats;
        int next_hold;
        int idle;
        int busy;
        rx_beats  = 0;
        next_hold = 150;
        forever begin
            if (rx_beats >= next_hold) begin
                idle      = HOLD_CYCLES;
                next_hold = next_hold + 250;
            end else begin
                idle = pick_gap();
            end
            repeat (idle) begin
                i_out_ready <= 1'b0;
                @(posedge i_clk);
            end
            busy = $urandom_range(1, 40);
            repeat (busy) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
                if (o_out_valid && i_out_ready) begin
                    rx_beats++;
                end
            end
        end
    end

    initial begin
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] e;
        logic [DATA_W-1:0] m;
        bit                quiet;
        int                r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_operands(ALL_ONES, 32'd5, '0, 0);
        send_operands(32'd7, '0, '0, 0);
        send_operands(ALL_ONES, ALL_ONES, '0, 1);
        send_operands(32'd123, '0, 32'd1, 0);
        send_operands('0, '0, 32'd17, 0);
        send_operands(ALL_ONES, '0, ALL_ONES, 2);
        send_operands(ALL_ONES, ALL_ONES, 32'd1, 0);
        send_operands('0, 32'd1, 32'd1, 0);
        send_operands('0, 32'd5, 32'd97, 0);
        send_operands(ALL_ONES, ALL_ONES, ALL_ONES, 0);
        send_operands(32'd1000, 32'd3, 32'd7, 3);
        send_operands(ALL_ONES, ALL_ONES, 32'd2, 0);
        send_operands(32'd46340, 32'd2, 32'd46341, 0);
        send_operands(32'hFFFF_FFFE, ALL_ONES, 32'hFFFF_FFFB, 0);
        send_operands(32'd3, 32'd31, 32'h8000_0000, 0);
        send_operands(32'd2, 32'd31, ALL_ONES, 1);
        send_operands(32'd1, ALL_ONES, ALL_ONES, 0);
        send_operands(32'd97, 32'd3, 32'd97, 0);
        send_operands(32'd12345, 32'd1, 32'd1000, 0);
        send_operands(32'd3, 32'h8000_0000, 32'd1000003, 0);
        send_operands(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAB, 0);
        wait_results_drained();

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i == RANDOM_BEATS / 2) begin
                wait_results_drained();
            end
            quiet = ((i / 40) % 3) == 1;
            m = pick_modulus();
            e = pick_exponent();
            r = $urandom_range(0, 99);
            if (r < 10) begin
                b = m;
            end else if (r < 25) begin
                b = DATA_W'($urandom_range(0, 15));
            end else begin
                b = DATA_W'($urandom);
            end
            send_operands(b, e, m, quiet ? 0 : pick_gap());
        end
        wait_results_drained();
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d operand sets: %0d with zero modulus, %0d with zero exponent",
                 n_sent, n_zero_mod, n_zero_exp);
        $display("Compared %0d results against the square-and-multiply predictor", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
